[rtl/core/tsm_pkg.sv]
// Shared types, codes and sizes of the two-way sorted merge block.
// Used by every module in rtl/core; depends on nothing else.
package tsm_pkg;

  // Field widths of the item ports (fixed by the interface).
  localparam int CMD_W  = 2;
  localparam int DATA_W = 32;

  // Default storage sizes.
  localparam int LIST_DEPTH    = 32;
  localparam int ELEMENT_WIDTH = 32;

  // Entries of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Command codes on cmd_i.
  localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MERGE       = 2'd2;

  // Classified operation handed from the front to the back.
  typedef enum logic [1:0] {
    OP_LOAD_FIRST,
    OP_LOAD_SECOND,
    OP_MERGE
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] value;
  } queue_entry_t;

  // Handshake between the queue and the back.
  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_head_t;

  // Address width of a store of the given depth (at least one bit).
  function automatic int idx_width(input int depth);
    idx_width = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

[rtl/core/tsm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on tsm_pkg for the address width helper.
module tsm_ram
  import tsm_pkg::*;
#(
  parameter int Width = ELEMENT_WIDTH,
  parameter int Depth = LIST_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [idx_width(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]            wdata_i,
  input  logic [idx_width(Depth)-1:0] raddr_i,
  output logic [Width-1:0]            rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tsm_front.sv]
// Front end: takes input items, classifies the command and pushes an
// operation into the queue. Depends on tsm_pkg.
module tsm_front
  import tsm_pkg::*;
(
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output queue_entry_t      q_entry_o
);

  logic accept;
  logic known;

  // Stall while the queue has no room
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Decode the command; the unused code is taken and dropped
  always_comb begin
    known           = 1'b1;
    q_entry_o.op    = OP_MERGE;
    q_entry_o.value = signed'(value_i);
    unique case (cmd_i)
      CMD_LOAD_FIRST:  q_entry_o.op = OP_LOAD_FIRST;
      CMD_LOAD_SECOND: q_entry_o.op = OP_LOAD_SECOND;
      CMD_MERGE:       q_entry_o.op = OP_MERGE;
      default:         known        = 1'b0;
    endcase
  end

  assign q_push_o = accept && known;

endmodule

[rtl/core/tsm_queue.sv]
// Short queue of classified operations between the front and the back.
// Depends on tsm_pkg.
module tsm_queue
  import tsm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  queue_entry_t entry_i,
  output logic         full_o,
  input  logic         pop_i,
  output queue_head_t  head_o
);

  localparam int PtrW = idx_width(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t    slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_pop;

  assign full_o       = (count_q == CntW'(QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = slot_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || do_pop)
    else $error("queue push while full");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue occupancy out of range");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers differ while empty");
`endif

endmodule

[rtl/core/tsm_back.sv]
// Back end: executes loads into the two list memories and walks both
// lists on a merge, emitting one result per value. Depends on tsm_pkg
// and tsm_ram.
module tsm_back
  import tsm_pkg::*;
#(
  parameter int ListDepth = LIST_DEPTH,
  parameter int ElemW     = ELEMENT_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  queue_head_t       head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] merged_value_o,
  output logic              last_o,
  output logic              overflow_o
);

  localparam int IdxW = idx_width(ListDepth);
  localparam int CntW = $clog2(ListDepth + 1);

  localparam logic [0:0] ST_IDLE  = 1'b0;
  localparam logic [0:0] ST_MERGE = 1'b1;

  logic [0:0]        state_q, state_d;
  logic [CntW-1:0]   first_cnt_q, first_cnt_d;
  logic [CntW-1:0]   second_cnt_q, second_cnt_d;
  logic [CntW-1:0]   i_q, i_d;
  logic [CntW-1:0]   j_q, j_d;
  logic              drop_q, drop_d;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;
  logic              out_last_q, out_last_d;
  logic              out_ovf_q, out_ovf_d;

  logic              we_first, we_second;
  logic [ElemW-1:0]  rdata_first, rdata_second;
  logic signed [63:0] in_wide;
  logic [ElemW-1:0]  elem_in;
  logic [ElemW-1:0]  pick;
  logic signed [63:0] pick_wide;
  logic              have_first, have_second, take_first, emit;

  // Sign-extend the 32-bit load value, then cut to the element width
  assign in_wide = 64'(head_i.entry.value);
  assign elem_in = in_wide[ElemW-1:0];

  // Widen the chosen element back to the result width
  assign pick_wide = 64'($signed(pick));

  assign pop_o = head_i.valid && (state_q == ST_IDLE);

  // Merge selection; equal values take the first list
  assign have_first  = (i_q < first_cnt_q);
  assign have_second = (j_q < second_cnt_q);
  assign take_first  = have_first &&
                       (!have_second || ($signed(rdata_first) <= $signed(rdata_second)));
  assign pick        = take_first ? rdata_first : rdata_second;
  assign emit        = (state_q == ST_MERGE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    first_cnt_d  = first_cnt_q;
    second_cnt_d = second_cnt_q;
    i_d          = i_q;
    j_d          = j_q;
    drop_d       = drop_q;
    we_first     = 1'b0;
    we_second    = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    out_ovf_d    = out_ovf_q;

    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          case (head_i.entry.op)
            OP_LOAD_FIRST: begin
              if (first_cnt_q == CntW'(ListDepth)) begin
                drop_d = 1'b1;
              end else begin
                we_first    = 1'b1;
                first_cnt_d = first_cnt_q + CntW'(1);
              end
            end
            OP_LOAD_SECOND: begin
              if (second_cnt_q == CntW'(ListDepth)) begin
                drop_d = 1'b1;
              end else begin
                we_second    = 1'b1;
                second_cnt_d = second_cnt_q + CntW'(1);
              end
            end
            default: begin
              // Merge: an empty pair only clears the overflow flag
              if (first_cnt_q == '0 && second_cnt_q == '0) begin
                drop_d = 1'b0;
              end else begin
                state_d = ST_MERGE;
              end
            end
          endcase
        end
      end
      default: begin
        if (emit) begin
          if (take_first) begin
            i_d = i_q + CntW'(1);
          end else begin
            j_d = j_q + CntW'(1);
          end
          out_valid_d = 1'b1;
          out_value_d = pick_wide[DATA_W-1:0];
          out_ovf_d   = drop_q;
          out_last_d  = (i_d == first_cnt_q) && (j_d == second_cnt_q);
          // Drop both lists after the final value
          if (out_last_d) begin
            state_d      = ST_IDLE;
            i_d          = '0;
            j_d          = '0;
            first_cnt_d  = '0;
            second_cnt_d = '0;
            drop_d       = 1'b0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      i_q          <= '0;
      j_q          <= '0;
      drop_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      first_cnt_q  <= first_cnt_d;
      second_cnt_q <= second_cnt_d;
      i_q          <= i_d;
      j_q          <= j_d;
      drop_q       <= drop_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload holds while stalled
  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  // List memories; the read address follows the next head index so the
  // head data is ready in the cycle the index takes effect
  tsm_ram #(
    .Width (ElemW),
    .Depth (ListDepth)
  ) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (we_first),
    .waddr_i (first_cnt_q[IdxW-1:0]),
    .wdata_i (elem_in),
    .raddr_i (i_d[IdxW-1:0]),
    .rdata_o (rdata_first)
  );

  tsm_ram #(
    .Width (ElemW),
    .Depth (ListDepth)
  ) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (we_second),
    .waddr_i (second_cnt_q[IdxW-1:0]),
    .wdata_i (elem_in),
    .raddr_i (j_d[IdxW-1:0]),
    .rdata_o (rdata_second)
  );

  assign out_valid_o    = out_valid_q;
  assign merged_value_o = out_value_q;
  assign last_o         = out_last_q;
  assign overflow_o     = out_ovf_q;

`ifndef ASSERT_OFF
  a_idle_heads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (i_q == '0) && (j_q == '0))
    else $error("head indexes not cleared while idle");
  a_heads_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (i_q <= first_cnt_q) && (j_q <= second_cnt_q))
    else $error("head index beyond list fill");
  a_counts_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (first_cnt_q <= CntW'(ListDepth)) && (second_cnt_q <= CntW'(ListDepth)))
    else $error("list fill beyond depth");
  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_last_d) |=> (state_q == ST_IDLE) && (first_cnt_q == '0) &&
                             (second_cnt_q == '0) && !drop_q)
    else $error("lists not emptied after final result");
  a_no_pop_merging: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> !pop_o)
    else $error("queue popped during a merge");
`endif

endmodule

[rtl/core/two_way_sorted_merge.sv]
// Two-way sorted merge: the front end accepts one command per cycle into a two-entry queue
// and stalls only while that queue is full. A load is written at the edge it leaves the
// queue. A merge holds the back end to its last result and emits one result per cycle while
// out_stall_i is low; from an idle back end its first result passes the queue slot, the
// merge state and the output register. Reset clears the list fills, overflow flag, queue
// and output valid; list memories keep their contents, since reads are gated by the fills.
module two_way_sorted_merge
  import tsm_pkg::*;
#(
  parameter int ListDepth = LIST_DEPTH,
  parameter int ElemW     = ELEMENT_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [DATA_W-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] merged_value_o,
  output logic              last_o,
  output logic              overflow_o
);

  logic         q_full;
  logic         q_push;
  logic         q_pop;
  queue_entry_t q_entry;
  queue_head_t  q_head;

  // Accept and classify items
  tsm_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  // Decouple front and back
  tsm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head)
  );

  // Store lists and run merges
  tsm_back #(
    .ListDepth (ListDepth),
    .ElemW     (ElemW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (q_head),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .merged_value_o (merged_value_o),
    .last_o         (last_o),
    .overflow_o     (overflow_o)
  );

endmodule
